// ===== hw/rtl/pwg_pkg.sv =====
// Shared types and constants of the parallel single-wire pixel waveform generator.
// Used by every module of the block; depends on nothing.
package pwg_pkg;

   localparam int CHANNELS_DEFAULT = 8;
   localparam int QUEUE_DEPTH      = 2;

   localparam int WORD_WIDTH       = 24;
   localparam int BIT_INDEX_WIDTH  = 5;
   localparam int TICK_WIDTH       = 10;
   localparam int LINE_WIDTH       = 8;
   localparam int KIND_WIDTH       = 2;
   localparam int CHANNEL_WIDTH    = 3;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 10;

   localparam logic [BIT_INDEX_WIDTH-1:0] TOP_BIT_INDEX = BIT_INDEX_WIDTH'(WORD_WIDTH - 1);

   // Request kinds as they arrive on the input port.
   localparam logic [KIND_WIDTH-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_COMMIT = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_TICK   = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHANNEL_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_T0H_TICKS      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_T1H_TICKS      = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_TICKS   = 2'd3;

   // Operation of a classified request.
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_COMMIT,
      OP_TICK,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [CHANNEL_WIDTH-1:0] channel;
      logic [WORD_WIDTH-1:0]    pixel_word;
   } cmd_type;

   typedef struct packed {
      logic [LINE_WIDTH-1:0] line_levels;
      logic                  busy_res;
      logic                  row_done;
      logic                  commit_dropped;
   } rsp_type;

   typedef struct packed {
      logic [LINE_WIDTH-1:0] channel_enable;
      logic [TICK_WIDTH-1:0] t0h_ticks;
      logic [TICK_WIDTH-1:0] t1h_ticks;
      logic [TICK_WIDTH-1:0] period_ticks;
   } cfg_type;

endpackage

// ===== hw/rtl/pwg_fifo.sv =====
// Small first-in first-out queue of packed words, used between the front and back
// parts and on the result side. Depends on pwg_pkg for its default depth.
module pwg_fifo
   import pwg_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/pwg_front.sv =====
// Request classifier: turns an incoming request into an operation for the back part
// and applies flow control from the command queue. Depends on pwg_pkg.
module pwg_front
   import pwg_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [KIND_WIDTH-1:0]    req_kind,
   input  logic [CHANNEL_WIDTH-1:0] req_channel,
   input  logic [WORD_WIDTH-1:0]    req_pixel_word,
   input  logic                     cmd_full,
   output logic                     cmd_push,
   output cmd_type                  cmd
);

   logic channel_valid;

   // A load to a channel that does not exist has no effect, so it becomes a no-op here.
   assign channel_valid = (32'(req_channel) < CHANNELS);

   assign full     = cmd_full || reset;
   assign cmd_push = push && !full;

   always_comb begin
      cmd.channel    = req_channel;
      cmd.pixel_word = req_pixel_word;
      case (req_kind)
         KIND_LOAD:   cmd.op = channel_valid ? OP_LOAD : OP_NOP;
         KIND_COMMIT: cmd.op = OP_COMMIT;
         KIND_TICK:   cmd.op = OP_TICK;
         default:     cmd.op = OP_NOP;
      endcase
   end

endmodule

// ===== hw/rtl/pwg_back.sv =====
// Bit timing engine: staging buffer, shift registers, bit and phase counters, and the
// line level logic. Executes one classified request per cycle unless stalled. Depends on pwg_pkg.
module pwg_back
   import pwg_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);

   localparam int LINES = (CHANNELS < LINE_WIDTH) ? CHANNELS : LINE_WIDTH;

   logic [WORD_WIDTH-1:0]      staging_ff [CHANNELS];
   logic [WORD_WIDTH-1:0]      staging_in [CHANNELS];
   logic [WORD_WIDTH-1:0]      shift_ff   [CHANNELS];
   logic [WORD_WIDTH-1:0]      shift_in   [CHANNELS];
   logic [BIT_INDEX_WIDTH-1:0] bit_index_ff, bit_index_in;
   logic [TICK_WIDTH-1:0]      phase_ff, phase_in;
   logic                       sending_ff, sending_in;

   logic                  go;
   logic                  starting;
   logic                  done;
   logic                  dropped;
   logic [TICK_WIDTH-1:0] phase_next;
   logic [TICK_WIDTH-1:0] one_end;
   logic [TICK_WIDTH-1:0] eval_phase;
   logic                  eval_sending;
   logic                  early_high;
   logic                  late_high;
   logic [LINE_WIDTH-1:0] levels;

   assign go       = cmd_valid && !rsp_full;
   assign cmd_pop  = go;
   assign rsp_push = go;

   assign phase_next = phase_ff + TICK_WIDTH'(1);
   assign one_end    = (cfg.t1h_ticks > cfg.t0h_ticks) ? cfg.t1h_ticks : cfg.t0h_ticks;

   always_comb begin
      staging_in   = staging_ff;
      shift_in     = shift_ff;
      bit_index_in = bit_index_ff;
      phase_in     = phase_ff;
      sending_in   = sending_ff;
      starting     = 1'b0;
      done         = 1'b0;
      dropped      = 1'b0;
      if (go) begin
         case (cmd.op)
            OP_LOAD: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (32'(cmd.channel) == c) begin
                     staging_in[c] = cmd.pixel_word;
                  end
               end
            end
            OP_COMMIT: begin
               if (sending_ff) begin
                  dropped = 1'b1;
               end else begin
                  shift_in     = staging_ff;
                  bit_index_in = TOP_BIT_INDEX;
                  phase_in     = '0;
                  sending_in   = 1'b1;
                  starting     = 1'b1;
               end
            end
            OP_TICK: begin
               if (sending_ff) begin
                  if (phase_next >= cfg.period_ticks) begin
                     phase_in = '0;
                     if (bit_index_ff == '0) begin
                        sending_in   = 1'b0;
                        bit_index_in = TOP_BIT_INDEX;
                        done         = 1'b1;
                     end else begin
                        bit_index_in = bit_index_ff - BIT_INDEX_WIDTH'(1);
                        for (int c = 0; c < CHANNELS; c++) begin
                           shift_in[c] = {shift_ff[c][WORD_WIDTH-2:0], 1'b0};
                        end
                     end
                  end else begin
                     phase_in = phase_next;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // A tick reports the level during that tick, so only a starting commit looks ahead.
   assign eval_phase   = starting ? '0 : phase_ff;
   assign eval_sending = starting || sending_ff;
   assign early_high   = (eval_phase < cfg.t0h_ticks);
   assign late_high    = (eval_phase < one_end);

   for (genvar g = 0; g < LINES; g++) begin : g_line
      logic msb;
      assign msb = starting ? staging_ff[g][WORD_WIDTH-1] : shift_ff[g][WORD_WIDTH-1];
      assign levels[g] = eval_sending && cfg.channel_enable[g] && (early_high || (msb && late_high));
   end
   if (LINES < LINE_WIDTH) begin : g_unused_lines
      assign levels[LINE_WIDTH-1:LINES] = '0;
   end

   assign rsp.line_levels    = levels;
   assign rsp.busy_res       = sending_in;
   assign rsp.row_done       = done;
   assign rsp.commit_dropped = dropped;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            staging_ff[c] <= '0;
         end
         bit_index_ff <= TOP_BIT_INDEX;
         phase_ff     <= '0;
         sending_ff   <= 1'b0;
      end else begin
         staging_ff   <= staging_in;
         bit_index_ff <= bit_index_in;
         phase_ff     <= phase_in;
         sending_ff   <= sending_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

// ===== hw/rtl/parallel_ws2812_waveform_generator_core.sv =====
// Top level of the parallel single-wire pixel waveform generator.
// Depends on pwg_pkg, pwg_front, pwg_fifo and pwg_back.
//
// This block drives up to eight single-wire pixel data lines in lockstep. A load request
// writes one 24-bit word, already in wire order, into the staging slot of one channel; a
// commit request copies all staging slots into the shift registers at once and starts
// a row; every tick request advances the bit timing by one tick. Within each bit period an
// enabled line is high from the period start, lines sending a 0 bit drop at t0h_ticks and
// all lines drop at the larger of t0h_ticks and t1h_ticks; bits leave MSB first, one per
// period_ticks ticks. Every request yields exactly one response that carries the line
// levels (for a tick, the level during that tick; otherwise the level after the request),
// the busy state after the request, a row done flag on the tick that ends bit 0, and a
// flag for a commit that arrived while a row was in flight and was ignored. The block takes
// one request per clock cycle while the command queue has room; a response passes through
// the command queue and the timing engine into the result queue, which holds it until a pop.
// A classifier in front feeds a two-entry command queue, the timing engine behind it
// executes one request per cycle while the result queue has room, and a two-entry result
// queue decouples it from the consumer, so either side may stall without losing a request.
// The user must write configuration registers through the csr port only while the block is
// idle; the block does not enforce this. channel_enable acts on responses computed after it.
module parallel_ws2812_waveform_generator_core
   import pwg_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [KIND_WIDTH-1:0]      req_kind,
   input  logic [CHANNEL_WIDTH-1:0]   req_channel,
   input  logic [WORD_WIDTH-1:0]      req_pixel_word,
   output logic                       empty,
   input  logic                       pop,
   output logic [LINE_WIDTH-1:0]      rsp_line_levels,
   output logic                       rsp_busy_res,
   output logic                       rsp_row_done,
   output logic                       rsp_commit_dropped,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_wr, cmd_rd;
   logic    rsp_push, rsp_full, rsp_empty;
   rsp_type rsp_wr, rsp_rd;

   // Configuration registers. The write data is as wide as the widest register; each
   // register keeps its own low bits.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CHANNEL_ENABLE: cfg_in.channel_enable = csr_wdata[LINE_WIDTH-1:0];
            CSR_T0H_TICKS:      cfg_in.t0h_ticks      = csr_wdata[TICK_WIDTH-1:0];
            CSR_T1H_TICKS:      cfg_in.t1h_ticks      = csr_wdata[TICK_WIDTH-1:0];
            CSR_PERIOD_TICKS:   cfg_in.period_ticks   = csr_wdata[TICK_WIDTH-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_enable <= '0;
         cfg_ff.t0h_ticks      <= TICK_WIDTH'(8);
         cfg_ff.t1h_ticks      <= TICK_WIDTH'(16);
         cfg_ff.period_ticks   <= TICK_WIDTH'(25);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front part: classify each request and hand it to the command queue.
   pwg_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_kind       (req_kind),
      .req_channel    (req_channel),
      .req_pixel_word (req_pixel_word),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd            (cmd_wr)
   );

   pwg_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rd),
      .empty (cmd_empty)
   );

   // Back part: the timing engine consumes a request only when the result queue has room.
   pwg_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   pwg_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rd),
      .empty (rsp_empty)
   );

   assign empty              = rsp_empty || reset;
   assign rsp_line_levels    = rsp_rd.line_levels;
   assign rsp_busy_res       = rsp_rd.busy_res;
   assign rsp_row_done       = rsp_rd.row_done;
   assign rsp_commit_dropped = rsp_rd.commit_dropped;

endmodule

// ===== hw/rtl/pwg_checker.sv =====
// Port-level checker of the parallel single-wire pixel waveform generator, bound to the
// top level. Depends on pwg_pkg for field widths.
module pwg_checker
   import pwg_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  full,
   input logic                  empty,
   input logic                  pop,
   input logic [LINE_WIDTH-1:0] rsp_line_levels,
   input logic                  rsp_busy_res,
   input logic                  rsp_row_done,
   input logic                  rsp_commit_dropped
);

   // The result queue comes out of reset empty. The input side reports full while
   // reset is held, so only the result side is checked here.
   a_reset_state: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result queue not empty after reset");

   // The request that finishes a row leaves the block idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_row_done |-> !rsp_busy_res)
      else $error("row done reported while still busy");

   // A commit is only dropped while a row is in flight.
   a_drop_busy: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_commit_dropped |-> rsp_busy_res && !rsp_row_done)
      else $error("commit dropped while idle");

   // Outside a row all lines are low.
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_busy_res && !rsp_row_done |-> rsp_line_levels == '0)
      else $error("line driven high while idle");

   // A waiting response holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_line_levels) && $stable(rsp_busy_res)
         && $stable(rsp_row_done) && $stable(rsp_commit_dropped))
      else $error("response changed while stalled");

endmodule

bind parallel_ws2812_waveform_generator_core pwg_checker u_pwg_checker (
   .clock              (clock),
   .reset              (reset),
   .full               (full),
   .empty              (empty),
   .pop                (pop),
   .rsp_line_levels    (rsp_line_levels),
   .rsp_busy_res       (rsp_busy_res),
   .rsp_row_done       (rsp_row_done),
   .rsp_commit_dropped (rsp_commit_dropped)
);

// ===== sim/tb_parallel_ws2812_waveform_generator_core.sv =====
// Self-checking testbench for the parallel single-wire pixel waveform generator core.
// Depends on pwg_pkg and parallel_ws2812_waveform_generator_core with the files that it uses.
// A directed table is followed by phases of random rows and ticks, all checked in order.
`timescale 1ns / 100ps

module tb_parallel_ws2812_waveform_generator_core;
   import pwg_pkg::*;

   localparam int CH_COUNT      = CHANNELS_DEFAULT;
   localparam int MAX_REPORTS   = 10;
   localparam int LONG_HOLD     = 250;
   localparam int RANDOM_PHASES = 9;
   localparam int DIRECTED_ROWS = 22;

   // The package names three request kinds; the fourth encoding must do nothing.
   localparam logic [KIND_WIDTH-1:0] KIND_UNUSED = 2'd3;

   // A row of the directed table is either one request (repeated reps times) or a
   // register write. When typed is set, want is the response written out by hand.
   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_op_type;

   typedef struct packed {
      row_op_type                 op;
      logic [KIND_WIDTH-1:0]      kind;
      logic [CHANNEL_WIDTH-1:0]   channel;
      logic [WORD_WIDTH-1:0]      word;
      logic [CSR_INDEX_WIDTH-1:0] csr_idx;
      logic [CSR_DATA_WIDTH-1:0]  csr_val;
      logic [5:0]                 reps;
      logic                       typed;
      rsp_type                    want;
   } stim_row_type;

   logic                       clock;
   logic                       reset;
   logic                       push;
   logic                       full;
   logic [KIND_WIDTH-1:0]      req_kind;
   logic [CHANNEL_WIDTH-1:0]   req_channel;
   logic [WORD_WIDTH-1:0]      req_pixel_word;
   logic                       empty;
   logic                       pop;
   logic [LINE_WIDTH-1:0]      rsp_line_levels;
   logic                       rsp_busy_res;
   logic                       rsp_row_done;
   logic                       rsp_commit_dropped;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   // Predictor state: the register set and the pixel row engine as the block should hold them.
   cfg_type               line_cfg;
   logic [WORD_WIDTH-1:0] staged_words [CH_COUNT];
   logic [WORD_WIDTH-1:0] shift_words [CH_COUNT];
   logic [BIT_INDEX_WIDTH-1:0] bit_pos;
   logic [TICK_WIDTH-1:0] phase_ticks;
   logic                  row_active;

   // Responses still owed by the block, oldest first.
   rsp_type pending_rsp [$];

   int           mismatches;
   int           requests_sent;
   int           idle_pct;
   int           hold_asks;
   stim_row_type directed_rows [DIRECTED_ROWS];

   parallel_ws2812_waveform_generator_core #(
      .CHANNELS(CH_COUNT)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_kind           (req_kind),
      .req_channel        (req_channel),
      .req_pixel_word     (req_pixel_word),
      .empty              (empty),
      .pop                (pop),
      .rsp_line_levels    (rsp_line_levels),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_row_done       (rsp_row_done),
      .rsp_commit_dropped (rsp_commit_dropped),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block stops answering; a correct run ends far earlier.
   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Level of every data line at the current bit position. An enabled line is high
   // before t0h, and a line sending a 1 stays high until the larger threshold.
   function automatic logic [LINE_WIDTH-1:0] line_pattern();
      logic [LINE_WIDTH-1:0] levels;
      logic [TICK_WIDTH-1:0] one_end;
      levels = '0;
      if (!row_active) begin
         return levels;
      end
      one_end = (line_cfg.t1h_ticks > line_cfg.t0h_ticks) ? line_cfg.t1h_ticks
                                                          : line_cfg.t0h_ticks;
      for (int c = 0; c < CH_COUNT && c < LINE_WIDTH; c++) begin
         if (line_cfg.channel_enable[c] &&
             (phase_ticks < line_cfg.t0h_ticks ||
              (shift_words[c][bit_pos] && phase_ticks < one_end))) begin
            levels[c] = 1'b1;
         end
      end
      return levels;
   endfunction

   // Applies one accepted request to the predictor and returns the response it must cause.
   function automatic rsp_type predict_response(logic [KIND_WIDTH-1:0] kind,
                                                logic [CHANNEL_WIDTH-1:0] ch,
                                                logic [WORD_WIDTH-1:0] word);
      rsp_type               resp;
      logic [TICK_WIDTH-1:0] next_phase;
      resp = '0;
      case (kind)
         KIND_LOAD: begin
            // Loads are legal at any time and only touch the staging buffer.
            if (ch < CH_COUNT) begin
               staged_words[ch] = word;
            end
            resp.line_levels = line_pattern();
         end
         KIND_COMMIT: begin
            if (row_active) begin
               resp.commit_dropped = 1'b1;
            end else begin
               shift_words = staged_words;
               bit_pos     = TOP_BIT_INDEX;
               phase_ticks = '0;
               row_active  = 1'b1;
            end
            resp.line_levels = line_pattern();
         end
         KIND_TICK: begin
            // A tick reports the level during the tick, before the timing advances.
            resp.line_levels = line_pattern();
            if (row_active) begin
               next_phase = phase_ticks + 1'b1;
               if (next_phase >= line_cfg.period_ticks) begin
                  phase_ticks = '0;
                  if (bit_pos == '0) begin
                     row_active   = 1'b0;
                     bit_pos      = TOP_BIT_INDEX;
                     resp.row_done = 1'b1;
                  end else begin
                     bit_pos = bit_pos - 1'b1;
                  end
               end else begin
                  phase_ticks = next_phase;
               end
            end
         end
         default: begin
            resp.line_levels = line_pattern();
         end
      endcase
      resp.busy_res = row_active;
      return resp;
   endfunction

   // Idle length for either side: usually none or short, now and then long.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) >= idle_pct) begin
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [WORD_WIDTH-1:0] random_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return WORD_WIDTH'($urandom);
      endcase
   endfunction

   function automatic void check_response(rsp_type got);
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t: response with nothing expected: lines=%h busy=%b done=%b dropped=%b",
                     $time, got.line_levels, got.busy_res, got.row_done, got.commit_dropped);
         end
         return;
      end
      want = pending_rsp.pop_front();
      if (got.line_levels !== want.line_levels || got.busy_res !== want.busy_res ||
          got.row_done !== want.row_done || got.commit_dropped !== want.commit_dropped) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t: expected lines=%h busy=%b done=%b dropped=%b, got lines=%h busy=%b done=%b dropped=%b",
                     $time, want.line_levels, want.busy_res, want.row_done, want.commit_dropped,
                     got.line_levels, got.busy_res, got.row_done, got.commit_dropped);
         end
      end
   endfunction

   // Offers one request after a random gap and holds it until the block takes it.
   // Push stays high on return so that back-to-back requests need no extra edge.
   task automatic offer_request(logic [KIND_WIDTH-1:0] kind, logic [CHANNEL_WIDTH-1:0] ch,
                                logic [WORD_WIDTH-1:0] word, logic use_typed = 1'b0,
                                rsp_type typed = '0);
      int      gap;
      rsp_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind       <= kind;
      req_channel    <= ch;
      req_pixel_word <= word;
      push           <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      predicted = predict_response(kind, ch, word);
      pending_rsp.push_back(use_typed ? typed : predicted);
      requests_sent++;
   endtask

   // Register writes happen only once every owed response has come back. Every request
   // answers, so the extra cycles merely let the result queue settle.
   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                 logic [CSR_DATA_WIDTH-1:0] value);
      push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_CHANNEL_ENABLE: line_cfg.channel_enable = value[LINE_WIDTH-1:0];
         CSR_T0H_TICKS:      line_cfg.t0h_ticks      = value[TICK_WIDTH-1:0];
         CSR_T1H_TICKS:      line_cfg.t1h_ticks      = value[TICK_WIDTH-1:0];
         CSR_PERIOD_TICKS:   line_cfg.period_ticks   = value[TICK_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Result side: pops with random stalls, and on request from the stimulus holds off
   // for a long stretch so the queues fill and full reaches the sender.
   initial begin : response_side
      int      stall_left;
      int      hold_seen;
      rsp_type got;
      stall_left = 0;
      hold_seen  = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            got = '{rsp_line_levels, rsp_busy_res, rsp_row_done, rsp_commit_dropped};
            check_response(got);
         end
         if (hold_asks != hold_seen) begin
            hold_seen  = hold_asks;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      cfg_type      phase_cfg;
      int           budget;
      int           ticks_left;
      stim_row_type row;

      reset            <= 1'b1;
      push             <= 1'b0;
      req_kind         <= KIND_LOAD;
      req_channel      <= '0;
      req_pixel_word   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_CHANNEL_ENABLE;
      csr_wdata        <= '0;
      mismatches       = 0;
      requests_sent    = 0;
      hold_asks        = 0;
      idle_pct         = 25;

      // Reset values of the registers and of the row engine.
      line_cfg    = '{8'h00, 10'd8, 10'd16, 10'd25};
      bit_pos     = TOP_BIT_INDEX;
      phase_ticks = '0;
      row_active  = 1'b0;
      foreach (staged_words[c]) begin
         staged_words[c] = '0;
         shift_words[c]  = '0;
      end

      // Rows: op, kind, channel, word, register, value, repeats, typed, response.
      // The first block runs on reset settings with every line disabled. A commit with
      // all lines off still makes the block busy, and a second commit is dropped. With
      // a one-tick period the row ends after 24 ticks. Then a row with a 1/2/2 timing
      // shows the real bit pattern, and raising t0h past the period keeps lines high.
      directed_rows = '{
         '{ROW_REQ, KIND_TICK,   3'd0, 24'h000000, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b1,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_UNUSED, 3'd7, 24'hFFFFFF, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b1,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_LOAD,   3'd0, 24'hFFFFFF, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b1,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_LOAD,   3'd7, 24'h000000, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b1,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_LOAD,   3'd3, 24'hAAAAAA, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_LOAD,   3'd5, 24'h555555, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_COMMIT, 3'd0, 24'h000000, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b1,
           '{8'h00, 1'b1, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_COMMIT, 3'd0, 24'h000000, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b1,
           '{8'h00, 1'b1, 1'b0, 1'b1}},
         '{ROW_CSR, KIND_LOAD,   3'd0, 24'h000000, CSR_CHANNEL_ENABLE, 10'hFF, 6'd0, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_CSR, KIND_LOAD,   3'd0, 24'h000000, CSR_PERIOD_TICKS, 10'd1, 6'd0, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_TICK,   3'd0, 24'h000000, CSR_CHANNEL_ENABLE, 10'd0, 6'd23, 1'b1,
           '{8'hFF, 1'b1, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_TICK,   3'd0, 24'h000000, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b1,
           '{8'hFF, 1'b0, 1'b1, 1'b0}},
         '{ROW_REQ, KIND_TICK,   3'd0, 24'h000000, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b1,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_CSR, KIND_LOAD,   3'd0, 24'h000000, CSR_T0H_TICKS, 10'd1, 6'd0, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_CSR, KIND_LOAD,   3'd0, 24'h000000, CSR_T1H_TICKS, 10'd2, 6'd0, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_CSR, KIND_LOAD,   3'd0, 24'h000000, CSR_PERIOD_TICKS, 10'd2, 6'd0, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_COMMIT, 3'd0, 24'h000000, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b1,
           '{8'hFF, 1'b1, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_TICK,   3'd0, 24'h000000, CSR_CHANNEL_ENABLE, 10'd0, 6'd6, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_UNUSED, 3'd2, 24'h123456, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_LOAD,   3'd2, 24'h0F0F0F, CSR_CHANNEL_ENABLE, 10'd0, 6'd1, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_CSR, KIND_LOAD,   3'd0, 24'h000000, CSR_T0H_TICKS, 10'd5, 6'd0, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}},
         '{ROW_REQ, KIND_TICK,   3'd0, 24'h000000, CSR_CHANNEL_ENABLE, 10'd0, 6'd6, 1'b0,
           '{8'h00, 1'b0, 1'b0, 1'b0}}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.op == ROW_CSR) begin
            write_register(row.csr_idx, row.csr_val);
         end else begin
            repeat (row.reps) offer_request(row.kind, row.channel, row.word, row.typed, row.want);
         end
      end

      // Random phases. Each one picks a timing, then sends well-formed rows: a few loads,
      // a commit and enough ticks to finish the row, with stray requests mixed in. The
      // slowest timing cannot finish a row within its share, so that row is still in
      // flight when the next phase starts, which also exercises dropped commits.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: phase_cfg = '{8'hFF, 10'd1, 10'd2, 10'd3};
            1: phase_cfg = '{LINE_WIDTH'($urandom), 10'd2, 10'd1, 10'd4};
            2: phase_cfg = '{8'h00, 10'd1, 10'd1, 10'd2};
            3: phase_cfg = '{8'hA5, 10'd5, 10'd7, 10'd3};
            4: phase_cfg = '{8'hFF, 10'd1023, 10'd1023, 10'd1023};
            5: phase_cfg = '{8'h5A, 10'd1, 10'd1023, 10'd2};
            default: phase_cfg = '{LINE_WIDTH'($urandom), TICK_WIDTH'($urandom_range(1, 6)),
                                   TICK_WIDTH'($urandom_range(1, 6)),
                                   TICK_WIDTH'($urandom_range(2, 6))};
         endcase
         write_register(CSR_CHANNEL_ENABLE, CSR_DATA_WIDTH'(phase_cfg.channel_enable));
         write_register(CSR_T0H_TICKS, phase_cfg.t0h_ticks);
         write_register(CSR_T1H_TICKS, phase_cfg.t1h_ticks);
         write_register(CSR_PERIOD_TICKS, phase_cfg.period_ticks);

         // Some phases run with no idling at all on either side.
         idle_pct = (p == 0 || p == 4) ? 0 : 35;
         // Back-pressure: the result side stops popping for a long stretch while
         // requests keep coming.
         if (p == 1) begin
            hold_asks++;
         end
         budget = requests_sent + ((p == 4) ? 300 : 160);
         while (requests_sent < budget) begin
            repeat ($urandom_range(0, 2))
               offer_request(KIND_TICK, CHANNEL_WIDTH'($urandom), random_word());
            repeat ($urandom_range(0, 8))
               offer_request(KIND_LOAD, CHANNEL_WIDTH'($urandom), random_word());
            offer_request(KIND_COMMIT, CHANNEL_WIDTH'($urandom), random_word());
            ticks_left = WORD_WIDTH * phase_cfg.period_ticks + $urandom_range(0, 4);
            while (ticks_left > 0 && requests_sent < budget) begin
               if ($urandom_range(0, 99) < 6) begin
                  offer_request(KIND_WIDTH'($urandom), CHANNEL_WIDTH'($urandom), random_word());
               end else begin
                  offer_request(KIND_TICK, CHANNEL_WIDTH'($urandom), random_word());
                  ticks_left--;
               end
            end
         end
      end

      push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      // Anything the block still emits now would be a response nobody asked for.
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
